// ===== rtl/yuv420_pkg.sv =====
// ----------------------------------------------------------------------------
// yuv420_pkg - shared types and constants
// Sizes, stream payload layouts and BT.601 integer conversion helpers for the
// RGB to planar YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
package yuv420_pkg;

  // Frame size limits and derived counter widths
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CFG_W      = 13;
  localparam int CMP_W      = CFG_W + 2;

  localparam int LUMA_W     = 24;
  localparam int CHROMA_W   = 22;
  localparam int PIX_W      = 8;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  // Plane codes
  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_t;

  // Stream widths: tdata rounded to whole bytes
  localparam int S_DATA_W = 3 * PIX_W;
  localparam int M_FIELD_W = 2 + PIX_W + LUMA_W;
  localparam int M_DATA_W = ((M_FIELD_W + 7) / 8) * 8;

  // Position of one pixel within the frame, taken at input transfer
  typedef struct packed {
    logic                even_col;
    logic                even_row;
    logic                frame_end;
    logic [LUMA_W-1:0]   luma_idx;
    logic [CHROMA_W-1:0] chroma_idx;
  } pos_t;

  // Registered pixel with its position
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    pos_t             pos;
  } pix_t;

  // One result sample
  typedef struct packed {
    plane_t            plane;
    logic [PIX_W-1:0]  value;
    logic [LUMA_W-1:0] index;
    logic              last;
    logic              frame_end;
  } result_t;

  // Products of 8-bit components with signed weights stay within 18 bits
  localparam int SUM_W = 18;
  localparam logic signed [SUM_W-1:0] ROUND = 18'sd128;

  // Weighted sum plus rounding, then floor shift by 8 and wrapped offset
  function automatic logic [PIX_W-1:0] weigh(
    input logic [PIX_W-1:0] r,
    input logic [PIX_W-1:0] g,
    input logic [PIX_W-1:0] b,
    input logic signed [SUM_W-1:0] kr,
    input logic signed [SUM_W-1:0] kg,
    input logic signed [SUM_W-1:0] kb,
    input logic [PIX_W-1:0] offset
  );
    logic signed [SUM_W-1:0] rs;
    logic signed [SUM_W-1:0] gs;
    logic signed [SUM_W-1:0] bs;
    logic signed [SUM_W-1:0] sum;
    rs  = $signed({{(SUM_W-PIX_W){1'b0}}, r});
    gs  = $signed({{(SUM_W-PIX_W){1'b0}}, g});
    bs  = $signed({{(SUM_W-PIX_W){1'b0}}, b});
    sum = kr * rs + kg * gs + kb * bs + ROUND;
    // bits 15:8 of the two's complement sum are the floor quotient mod 256
    return sum[15:8] + offset;
  endfunction

endpackage

// ===== rtl/yuv420_pos.sv =====
// ----------------------------------------------------------------------------
// yuv420_pos - frame size registers and raster position counters
// Holds frame_width / frame_height and tracks column, row and per-plane
// sample counts; gives the position of the pixel being transferred in.
// ----------------------------------------------------------------------------
module yuv420_pos (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [yuv420_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [yuv420_pkg::CFG_W-1:0]     cfg_data,
  input  logic                             advance,
  output yuv420_pkg::pos_t                 pos
);
  import yuv420_pkg::*;

  logic [CFG_W-1:0]    frame_width;
  logic [CFG_W-1:0]    frame_height;
  logic [COL_W-1:0]    column_count;
  logic [ROW_W-1:0]    row_count;
  logic [LUMA_W-1:0]   luma_count;
  logic [CHROMA_W-1:0] u_count;
  logic [CHROMA_W-1:0] v_count;

  logic [CMP_W-1:0] width_eff;
  logic [CMP_W-1:0] height_eff;
  logic             row_end;
  logic             frame_end;

  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp sizes to [2, max]
  always_comb begin
    width_eff = CMP_W'(frame_width);
    if (width_eff < CMP_W'(2)) width_eff = CMP_W'(2);
    else if (width_eff > CMP_W'(MAX_WIDTH)) width_eff = CMP_W'(MAX_WIDTH);
    height_eff = CMP_W'(frame_height);
    if (height_eff < CMP_W'(2)) height_eff = CMP_W'(2);
    else if (height_eff > CMP_W'(MAX_HEIGHT)) height_eff = CMP_W'(MAX_HEIGHT);
  end

  assign row_end   = (CMP_W'(column_count) + CMP_W'(1)) >= width_eff;
  assign frame_end = row_end && ((CMP_W'(row_count) + CMP_W'(1)) >= height_eff);

  // Position of the current pixel
  always_comb begin
    pos.even_col   = ~column_count[0];
    pos.even_row   = ~row_count[0];
    pos.frame_end  = frame_end;
    pos.luma_idx   = luma_count;
    pos.chroma_idx = row_count[0] ? v_count : u_count;
  end

  // Counter update on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      luma_count   <= '0;
      u_count      <= '0;
      v_count      <= '0;
    end else if (advance) begin
      if (frame_end) begin
        column_count <= '0;
        row_count    <= '0;
        luma_count   <= '0;
        u_count      <= '0;
        v_count      <= '0;
      end else begin
        luma_count <= luma_count + LUMA_W'(1);
        if (~column_count[0]) begin
          if (row_count[0]) v_count <= v_count + CHROMA_W'(1);
          else              u_count <= u_count + CHROMA_W'(1);
        end
        if (row_end) begin
          column_count <= '0;
          row_count    <= row_count + ROW_W'(1);
        end else begin
          column_count <= column_count + COL_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/yuv420_conv.sv =====
// ----------------------------------------------------------------------------
// yuv420_conv - input pixel register
// Captures one RGB pixel with its frame position and holds it until the
// result stage takes it.
// ----------------------------------------------------------------------------
module yuv420_conv (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [yuv420_pkg::S_DATA_W-1:0]     in_data,
  input  yuv420_pkg::pos_t                    in_pos,
  output logic                                pix_valid,
  input  logic                                pix_take,
  output yuv420_pkg::pix_t                    pix
);
  import yuv420_pkg::*;

  logic pix_free;

  assign pix_free = !pix_valid || pix_take;
  assign in_ready = pix_free;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (pix_free) begin
      pix_valid <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (pix_free && in_valid) begin
      pix.red   <= in_data[PIX_W-1:0];
      pix.green <= in_data[2*PIX_W-1:PIX_W];
      pix.blue  <= in_data[3*PIX_W-1:2*PIX_W];
      pix.pos   <= in_pos;
    end
  end

endmodule

// ===== rtl/yuv420_out.sv =====
// ----------------------------------------------------------------------------
// yuv420_out - color conversion and result sequencer
// Converts the registered pixel into a luma and an optional chroma result,
// holds both, and sends them in order on the master stream.
// ----------------------------------------------------------------------------
module yuv420_out (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pix_valid,
  output logic                             pix_take,
  input  yuv420_pkg::pix_t                 pix,
  output logic                             out_valid,
  input  logic                             out_ready,
  output yuv420_pkg::result_t              out_res
);
  import yuv420_pkg::*;

  logic    pend_valid;
  logic    pend_two;
  logic    sel;
  result_t res0;
  result_t res1;
  result_t luma_next;
  result_t chroma_next;
  logic    last_xfer;
  logic    xfer;

  assign out_valid = pend_valid;
  assign out_res   = sel ? res1 : res0;
  assign xfer      = pend_valid && out_ready;
  assign last_xfer = xfer && (sel || !pend_two);
  assign pix_take  = pix_valid && (!pend_valid || last_xfer);

  // Conversion of the registered pixel
  always_comb begin
    luma_next.plane     = PLANE_Y;
    luma_next.value     = weigh(pix.red, pix.green, pix.blue,
                                18'sd66, 18'sd129, 18'sd25, 8'd16);
    luma_next.index     = pix.pos.luma_idx;
    luma_next.last      = !pix.pos.even_col;
    luma_next.frame_end = pix.pos.frame_end;

    chroma_next.index     = LUMA_W'(pix.pos.chroma_idx);
    chroma_next.last      = 1'b1;
    chroma_next.frame_end = pix.pos.frame_end;
    if (pix.pos.even_row) begin
      chroma_next.plane = PLANE_U;
      chroma_next.value = weigh(pix.red, pix.green, pix.blue,
                                -18'sd38, -18'sd74, 18'sd112, 8'd128);
    end else begin
      chroma_next.plane = PLANE_V;
      chroma_next.value = weigh(pix.red, pix.green, pix.blue,
                                18'sd112, -18'sd94, -18'sd18, 8'd128);
    end
  end

  // Pending pair control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_two   <= 1'b0;
      sel        <= 1'b0;
    end else if (pix_take) begin
      pend_valid <= 1'b1;
      pend_two   <= pix.pos.even_col;
      sel        <= 1'b0;
    end else if (last_xfer) begin
      pend_valid <= 1'b0;
      sel        <= 1'b0;
    end else if (xfer) begin
      sel <= 1'b1;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pix_take) begin
      res0 <= luma_next;
      res1 <= chroma_next;
    end
  end

`ifndef ASSERT_OFF
  // the chroma slot is only selected inside a two-result pixel
  a_sel_in_pair: assert property (@(posedge clk) disable iff (rst)
    sel |-> (pend_valid && pend_two))
    else $error("chroma selected outside a pair");

  // after the luma of a pair goes out, the chroma follows
  a_pair_advance: assert property (@(posedge clk) disable iff (rst)
    (xfer && !sel && pend_two) |=> (pend_valid && sel))
    else $error("pair did not advance to chroma");

  // the marked last result ends the pixel and frees the slot when no pixel waits
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (xfer && out_res.last && !pix_valid) |=> !pend_valid)
    else $error("slot still busy after last result");
`endif

endmodule

// ===== rtl/rgb24_to_yuv420_planar_top.sv =====
// ----------------------------------------------------------------------------
// rgb24_to_yuv420_planar_top - RGB24 to planar YUV 4:2:0 converter
// Integer BT.601 studio-range conversion of a raster pixel stream into
// plane-tagged, indexed luma and chroma samples.
// ----------------------------------------------------------------------------
//  channel   direction  transfer when          payload
//  s_*       in         s_tvalid & s_tready    one RGB pixel
//  m_*       out        m_tvalid & m_tready    one sample (plane, value, index)
//  cfg_*     in         cfg_valid & cfg_ready  frame_width / frame_height
//
//  Output: a pixel on an odd column gives one sample, one on an even column
//  two (luma, then chroma), sent in turn on the single master port.
//  From input transfer, a pixel passes the input pixel register, then the result registers.
//  Reset: synchronous; sizes return to 640x480 and all counters to zero.
//  Stalls: a stalled master holds its sample; one further pixel is taken into
//  the input register meanwhile, after which s_tready drops.
// ----------------------------------------------------------------------------
module rgb24_to_yuv420_planar_top (
  input  logic                              clk,
  input  logic                              rst,
  // slave stream, tdata: red[7:0], green[15:8], blue[23:16]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [yuv420_pkg::S_DATA_W-1:0]   s_tdata,
  // master stream, tdata: plane[1:0], sample_value[9:2], sample_index[33:10],
  // zero fill [39:34]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [yuv420_pkg::M_DATA_W-1:0]   m_tdata,
  output logic                              m_tlast,
  // master tuser: frame_end
  output logic                              m_tuser,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [yuv420_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [yuv420_pkg::CFG_W-1:0]      cfg_data
);
  import yuv420_pkg::*;

  pos_t    pos;
  pix_t    pix;
  logic    pix_valid;
  logic    pix_take;
  logic    in_xfer;
  result_t res;

  assign in_xfer = s_tvalid && s_tready;

  // Position counters and size registers
  yuv420_pos u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (in_xfer),
    .pos       (pos)
  );

  // Input pixel register
  yuv420_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .in_pos    (pos),
    .pix_valid (pix_valid),
    .pix_take  (pix_take),
    .pix       (pix)
  );

  // Conversion and result sequencing
  yuv420_out u_out (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_take  (pix_take),
    .pix       (pix),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // Master payload packing
  assign m_tdata = {{(M_DATA_W-M_FIELD_W){1'b0}}, res.index, res.value, res.plane};
  assign m_tlast = res.last;
  assign m_tuser = res.frame_end;

endmodule
